>>> sv/msp_pkg.sv
// Shared types and constants of the multi-channel servo pulse generator.
package msp_pkg;

	localparam logic [7:0] POS_OFF           = 8'd255;
	localparam logic [7:0] COUNT_TOP_RST     = 8'd250;
	localparam logic [7:0] BASE_PULSE_RST    = 8'd125;
	localparam logic [7:0] FRAME_MODULUS_RST = 8'd10;

	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	localparam logic [1:0] REG_COUNT_TOP     = 2'd0;
	localparam logic [1:0] REG_BASE_PULSE    = 2'd1;
	localparam logic [1:0] REG_FRAME_MODULUS = 2'd2;

	typedef enum logic [1:0] {
		PH_WAIT   = 2'd0,
		PH_MIN    = 2'd1,
		PH_WINDOW = 2'd2
	} phase_t;

	typedef struct packed {
		logic [1:0] command;
		logic [1:0] channel;
		logic [7:0] position;
	} in_word_t;

	typedef struct packed {
		logic [3:0] pin_levels;
		logic [7:0] read_position;
		logic [1:0] pulse_phase;
	} out_word_t;

	// What the timer tells the channel bank about the tick being processed.
	typedef struct packed {
		logic       raise;
		logic       window;
		logic [7:0] counter;
	} tick_info_t;

endpackage

>>> sv/msp_timer.sv
// Period counter, frame counter and pulse phase of the servo generator.
module msp_timer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                tick,
	input  logic [7:0]          count_top,
	input  logic [7:0]          base_pulse,
	input  logic [7:0]          frame_modulus,
	output msp_pkg::tick_info_t info,
	output msp_pkg::phase_t     phase_nxt
);

	logic [7:0]      counter_q;
	logic [7:0]      frame_q;
	msp_pkg::phase_t phase_q;

	logic [7:0] len;
	logic [8:0] next_cnt;
	logic [7:0] frame_dec;
	logic [7:0] counter_nxt;
	logic [7:0] frame_nxt;
	logic       raise;

	always_comb begin
		len         = (phase_q == msp_pkg::PH_MIN) ? base_pulse : count_top;
		next_cnt    = {1'b0, counter_q} + 9'd1;
		frame_dec   = frame_q - 8'd1;
		counter_nxt = counter_q;
		frame_nxt   = frame_q;
		phase_nxt   = phase_q;
		raise       = 1'b0;
		if (tick) begin
			if (next_cnt >= {1'b0, len}) begin
				counter_nxt = 8'd0;
				if (frame_dec > 8'd1) begin
					frame_nxt = frame_dec;
					phase_nxt = msp_pkg::PH_WAIT;
				end else if (frame_dec == 8'd1) begin
					frame_nxt = frame_dec;
					phase_nxt = msp_pkg::PH_MIN;
					raise     = 1'b1;
				end else begin
					frame_nxt = frame_modulus;
					phase_nxt = msp_pkg::PH_WINDOW;
				end
			end else begin
				counter_nxt = next_cnt[7:0];
			end
		end
		info.raise   = raise;
		info.window  = tick && (phase_nxt == msp_pkg::PH_WINDOW);
		info.counter = counter_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q <= 8'd0;
			frame_q   <= msp_pkg::FRAME_MODULUS_RST;
			phase_q   <= msp_pkg::PH_WAIT;
		end else if (tick) begin
			counter_q <= counter_nxt;
			frame_q   <= frame_nxt;
			phase_q   <= phase_nxt;
		end
	end

endmodule

>>> sv/msp_chan.sv
// Channel bank: stored positions and pin levels, one slice per channel.
module msp_chan #(
	parameter int NUM_CHANNELS = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  msp_pkg::tick_info_t info,
	input  logic                wr_en,
	input  logic                rd_en,
	input  logic [1:0]          channel,
	input  logic [7:0]          position,
	output logic [3:0]          pin_levels,
	output logic [7:0]          read_position
);

	logic [7:0]              pos_q [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] pins_q;
	logic [NUM_CHANNELS-1:0] pins_nxt;
	logic [NUM_CHANNELS-1:0] sel;

	always_comb begin
		pins_nxt      = pins_q;
		read_position = 8'd0;
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			sel[i] = ({2'b00, channel} == 4'(i));
			if (pos_q[i] != msp_pkg::POS_OFF) begin
				if (info.raise) pins_nxt[i] = 1'b1;
				if (info.window && (pos_q[i] <= info.counter)) pins_nxt[i] = 1'b0;
			end
			if (wr_en && sel[i] && (position == msp_pkg::POS_OFF)) pins_nxt[i] = 1'b0;
			if (rd_en && sel[i]) read_position = pos_q[i];
		end
	end

	// Only the first four channels are visible on the result word.
	for (genvar b = 0; b < 4; b++) begin : g_vis
		if (b < NUM_CHANNELS) begin : g_on
			assign pin_levels[b] = pins_nxt[b];
		end else begin : g_off
			assign pin_levels[b] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pins_q <= '0;
			for (int i = 0; i < NUM_CHANNELS; i++) pos_q[i] <= msp_pkg::POS_OFF;
		end else begin
			pins_q <= pins_nxt;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				if (wr_en && sel[i]) pos_q[i] <= position;
			end
		end
	end

endmodule

>>> sv/multi_channel_servo_pulse_generator.sv
// Top level of the multi-channel servo pulse generator.
//
// Each input word carries one command: a timer tick, a position write or a
// position read. Each accepted word produces exactly one result word with the
// pin levels after the command, the read-back position (zero unless the word
// was a read) and the pulse phase. Both channels use valid/stall: a word moves
// on a rising edge where valid is high and stall is low.
// A word accepted from the input sits in the input stage and is processed from
// there by the timer and channel bank; its result is registered in the output
// register when that register is free or being emptied, and is offered on the
// output from then on. A new word can be accepted on every cycle while the
// receiver does not stall, so the sustained rate is one word per clock.
// When the receiver stalls, the result stays in the output register and the
// input stage holds one more word; input stall rises only when both are full.
// Reset clears the period counter, sets the frame counter to its default,
// parks all positions at 255 (off), drives every pin low and restores the
// default configuration. Configuration writes land on the next edge and are
// meant to happen while no word is in flight.
module multi_channel_servo_pulse_generator #(
	parameter int NUM_CHANNELS = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  msp_pkg::in_word_t  in_word,
	output logic               out_valid,
	input  logic               out_stall,
	output msp_pkg::out_word_t out_word,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [7:0]         cfg_data
);

	logic [7:0] count_top_q;
	logic [7:0] base_pulse_q;
	logic [7:0] frame_modulus_q;

	logic              valid_s1;
	msp_pkg::in_word_t word_s1;
	logic              out_valid_q;
	msp_pkg::out_word_t out_word_q;

	logic                advance;
	logic                step;
	msp_pkg::tick_info_t info;
	msp_pkg::phase_t     phase_nxt;
	logic [3:0]          pin_levels;
	logic [7:0]          read_position;

	// The input stage moves forward whenever the output register is free or
	// being emptied this cycle.
	assign advance  = !out_valid_q || !out_stall;
	assign step     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_top_q     <= msp_pkg::COUNT_TOP_RST;
			base_pulse_q    <= msp_pkg::BASE_PULSE_RST;
			frame_modulus_q <= msp_pkg::FRAME_MODULUS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				msp_pkg::REG_COUNT_TOP:     count_top_q     <= cfg_data;
				msp_pkg::REG_BASE_PULSE:    base_pulse_q    <= cfg_data;
				msp_pkg::REG_FRAME_MODULUS: frame_modulus_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) word_s1 <= in_word;
	end

	msp_timer u_timer (
		.clk           (clk),
		.arst_n        (arst_n),
		.tick          (step && (word_s1.command == msp_pkg::CMD_TICK)),
		.count_top     (count_top_q),
		.base_pulse    (base_pulse_q),
		.frame_modulus (frame_modulus_q),
		.info          (info),
		.phase_nxt     (phase_nxt)
	);

	msp_chan #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_chan (
		.clk           (clk),
		.arst_n        (arst_n),
		.info          (info),
		.wr_en         (step && (word_s1.command == msp_pkg::CMD_WRITE)),
		.rd_en         (word_s1.command == msp_pkg::CMD_READ),
		.channel       (word_s1.channel),
		.position      (word_s1.position),
		.pin_levels    (pin_levels),
		.read_position (read_position)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_word_q.pin_levels    <= pin_levels;
			out_word_q.read_position <= read_position;
			out_word_q.pulse_phase   <= 2'(phase_nxt);
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule
